### hw/rtl/amte_pkg.sv
// ----------------------------------------------------------------------------
// amte_pkg: shared definitions for the affine matrix transform engine
// Request codes and saturating fixed-point helpers.
// ----------------------------------------------------------------------------
package amte_pkg;

  // request codes
  localparam logic [3:0] REQ_WR_CUR   = 4'd0;
  localparam logic [3:0] REQ_WR_OP    = 4'd1;
  localparam logic [3:0] REQ_CUR_OP   = 4'd2;
  localparam logic [3:0] REQ_OP_CUR   = 4'd3;
  localparam logic [3:0] REQ_POINT    = 4'd4;
  localparam logic [3:0] REQ_VECTOR   = 4'd5;
  localparam logic [3:0] REQ_INVERT   = 4'd6;
  localparam logic [3:0] REQ_SCALE    = 4'd7;
  localparam logic [3:0] REQ_READ     = 4'd8;
  localparam logic [3:0] REQ_IDENTITY = 4'd9;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  // saturating signed 64-bit add
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  // saturating signed 64-bit subtract
  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

endpackage

### hw/rtl/affine_matrix_transform_engine.sv
// ----------------------------------------------------------------------------
// affine_matrix_transform_engine: 4x4 fixed-point affine transform unit
// Holds a current and an operand matrix and runs requests on them with one
// shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage: a request is taken on the input channel when in_valid is high and
// in_stall low. Element writes, identity and unused codes finish in the cycle
// they are taken. Scale, point, vector, invert and compose requests walk the
// shared multiplier, one product at a time (operand fetch in S_LDA and S_LDB,
// four partial products, rounding, accumulate). in_stall stays high until
// the request is done. Point, vector and read requests give one result on
// the output channel (a read goes straight to the output step); the result
// register holds it while out_stall is high, and writes taken meanwhile do
// not touch it. A new result request waits in its last step until the
// register is free.
// Reset (rst, synchronous) loads identity into the current matrix and
// empties the result register; the operand matrix is undefined until written.
// ----------------------------------------------------------------------------
module affine_matrix_transform_engine #(
  parameter int FRAC_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         req_type,
  input  logic [3:0]         elem_index,
  input  logic signed [63:0] value_a,
  input  logic signed [63:0] value_b,
  input  logic signed [63:0] value_c,
  input  logic signed [63:0] value_d,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] res_x,
  output logic signed [63:0] res_y,
  output logic signed [63:0] res_z,
  output logic signed [63:0] res_w
);
  import amte_pkg::*;

  localparam logic signed [63:0] FX_ONE = 64'(1) << FRAC_BITS;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LDA   = 6'b000010,
    S_LDB   = 6'b000100,
    S_MUL   = 6'b001000,
    S_STORE = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t             state;
  logic [3:0]         op_code;
  logic [1:0]         row;
  logic [1:0]         col;
  logic [1:0]         k;
  logic signed [63:0] vin [4];
  logic signed [63:0] acc;
  logic signed [63:0] opa;
  logic signed [63:0] cur [16];
  logic signed [63:0] opm [16];
  logic signed [63:0] scr [16];
  logic signed [63:0] res_vec [4];

  logic               accept;
  logic               is_cmp;
  logic [1:0]         k_last;
  logic [1:0]         row_last;
  logic [3:0]         diag_idx;
  logic [3:0]         a_cur_addr;
  logic [3:0]         b_cur_addr;
  logic [3:0]         cur_addr;
  logic [3:0]         op_addr;
  logic signed [63:0] cur_rd;
  logic signed [63:0] op_rd;
  logic signed [63:0] b_sel;
  logic signed [63:0] a_sel;
  logic signed [63:0] acc_base;
  logic signed [63:0] acc_upd;
  logic               mul_start;
  logic               mul_done;
  logic signed [63:0] mul_p;
  logic               seq_last;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign mul_start = (state == S_LDB);
  assign is_cmp    = (op_code == REQ_CUR_OP) || (op_code == REQ_OP_CUR);

  // loop bounds per request
  always_comb begin
    case (op_code)
      REQ_INVERT: k_last = 2'd2;
      REQ_SCALE:  k_last = 2'd0;
      default:    k_last = 2'd3;
    endcase
    row_last = (is_cmp || op_code == REQ_VECTOR) ? 2'd3 : 2'd2;
    seq_last = (row == row_last) && (!is_cmp || col == 2'd3);
  end

  // read addresses, one per matrix
  always_comb begin
    diag_idx = {row, 2'b00} + {2'b00, row};
    case (op_code)
      REQ_INVERT: a_cur_addr = {row, k};
      REQ_SCALE:  a_cur_addr = diag_idx;
      REQ_POINT:  a_cur_addr = (k == 2'd3) ? {2'b11, row} : {k, row};
      default:    a_cur_addr = {k, row};
    endcase
    b_cur_addr = (op_code == REQ_INVERT) ? {2'b11, k} : {col, k};
    case (state)
      S_IDLE:  cur_addr = elem_index;
      S_LDB:   cur_addr = b_cur_addr;
      default: cur_addr = a_cur_addr;
    endcase
    op_addr = (state == S_LDA) ? {k, row} : {col, k};
    cur_rd  = cur[cur_addr];
    op_rd   = opm[op_addr];
  end

  // multiplier operands and accumulation
  always_comb begin
    a_sel = (op_code == REQ_OP_CUR) ? op_rd : cur_rd;
    case (op_code)
      REQ_POINT, REQ_VECTOR: b_sel = vin[k];
      REQ_CUR_OP:            b_sel = op_rd;
      REQ_SCALE:             b_sel = vin[0];
      default:               b_sel = cur_rd;
    endcase
    acc_base = (k == 2'd0) ? '0 : acc;
    acc_upd  = (op_code == REQ_INVERT) ? sat_sub(acc_base, mul_p)
                                       : sat_add(acc_base, mul_p);
  end

  amte_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (opa),
    .b     (b_sel),
    .done  (mul_done),
    .p     (mul_p)
  );

  // operand matrix and scratch, no reset
  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_WR_OP) opm[elem_index] <= value_a;
    if (state == S_STORE) begin
      if (is_cmp) scr[{col, row}] <= acc;
      else if (op_code == REQ_INVERT) scr[{2'b11, row}] <= acc;
    end
  end

  // sequencer, current matrix and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 16; i++) cur[i] <= (i % 5 == 0) ? FX_ONE : '0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_code <= req_type;
            vin[0]  <= value_a;
            vin[1]  <= value_b;
            vin[2]  <= value_c;
            vin[3]  <= value_d;
            row     <= '0;
            col     <= '0;
            k       <= '0;
            case (req_type)
              REQ_WR_CUR: cur[elem_index] <= value_a;
              REQ_IDENTITY: begin
                for (int i = 0; i < 16; i++) cur[i] <= (i % 5 == 0) ? FX_ONE : '0;
              end
              REQ_READ: begin
                res_vec[0] <= cur_rd;
                res_vec[1] <= '0;
                res_vec[2] <= '0;
                res_vec[3] <= '0;
                state      <= S_OUT;
              end
              REQ_CUR_OP, REQ_OP_CUR, REQ_POINT, REQ_VECTOR,
              REQ_INVERT, REQ_SCALE: state <= S_LDA;
              default: ;
            endcase
          end
        end
        S_LDA: begin
          if (op_code == REQ_POINT && k == 2'd3) begin
            acc   <= sat_add(acc, cur_rd);
            state <= S_STORE;
          end else begin
            opa   <= a_sel;
            state <= S_LDB;
          end
        end
        S_LDB: state <= S_MUL;
        S_MUL: begin
          if (mul_done) begin
            acc <= acc_upd;
            if (k == k_last) state <= S_STORE;
            else begin
              k     <= k + 2'd1;
              state <= S_LDA;
            end
          end
        end
        S_STORE: begin
          if (op_code == REQ_POINT || op_code == REQ_VECTOR) res_vec[row] <= acc;
          if (op_code == REQ_SCALE) cur[diag_idx] <= acc;
          k <= '0;
          if (!seq_last) begin
            row   <= (row == row_last) ? 2'd0 : row + 2'd1;
            if (row == row_last) col <= col + 2'd1;
            state <= S_LDA;
          end else begin
            case (op_code)
              REQ_CUR_OP, REQ_OP_CUR: begin
                for (int i = 0; i < 16; i++) cur[i] <= (i == 15) ? acc : scr[i];
                state <= S_IDLE;
              end
              REQ_INVERT: begin
                for (int r = 0; r < 3; r++)
                  for (int c = 0; c < 3; c++) cur[c * 4 + r] <= cur[r * 4 + c];
                cur[3]  <= '0;
                cur[7]  <= '0;
                cur[11] <= '0;
                cur[12] <= scr[12];
                cur[13] <= scr[13];
                cur[14] <= acc;
                cur[15] <= FX_ONE;
                state   <= S_IDLE;
              end
              REQ_POINT: begin
                res_vec[3] <= FX_ONE;
                state      <= S_OUT;
              end
              REQ_VECTOR: state <= S_OUT;
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            res_x     <= res_vec[0];
            res_y     <= res_vec[1];
            res_z     <= res_vec[2];
            res_w     <= res_vec[3];
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/amte_mul.sv
// ----------------------------------------------------------------------------
// amte_mul: shared fixed-point multiplier
// Sign-magnitude 64x64 multiply built from four 32x32 partial products, one
// per cycle, then truncation toward zero and saturation to 64 bits.
// ----------------------------------------------------------------------------
module amte_mul #(
  parameter int FRAC_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic               done,
  output logic signed [63:0] p
);
  import amte_pkg::*;

  logic [63:0]  ua;
  logic [63:0]  ub;
  logic         neg;
  logic [127:0] prod;
  logic [1:0]   step;
  logic         busy;
  logic         fin;

  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  pp;
  logic [1:0]   pos;
  logic [6:0]   shamt;
  logic         over;
  logic [63:0]  mag;

  // partial product for the current step
  always_comb begin
    pa    = step[0] ? ua[63:32] : ua[31:0];
    pb    = step[1] ? ub[63:32] : ub[31:0];
    pp    = {32'b0, pa} * {32'b0, pb};
    pos   = {1'b0, step[0]} + {1'b0, step[1]};
    shamt = {pos, 5'b0};
    over  = |(prod >> (64 + FRAC_BITS));
    mag   = prod[FRAC_BITS +: 64];
  end

  // step sequencing and rounding
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        ua   <= a[63] ? 64'(-a) : a;
        ub   <= b[63] ? 64'(-b) : b;
        neg  <= a[63] ^ b[63];
        prod <= '0;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        prod <= prod + ({64'b0, pp} << shamt);
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        done <= 1'b1;
        if (over) p <= neg ? S64_MIN : S64_MAX;
        else if (neg) p <= mag[63] ? S64_MIN : -$signed(mag);
        else p <= mag[63] ? S64_MAX : $signed(mag);
      end
    end
  end

endmodule

### hw/rtl/amte_chk.sv
// ----------------------------------------------------------------------------
// amte_chk: port-level checks for the affine matrix transform engine
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module amte_chk (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [3:0]         req_type,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [63:0] res_x,
  input logic signed [63:0] res_y
);
  import amte_pkg::*;

  logic accept;
  assign accept = in_valid && !in_stall;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res_x))
    else $error("result changed under stall");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // current-matrix element write makes no result
  a_wr_silent: assert property (@(posedge clk) disable iff (rst)
    accept && req_type == REQ_WR_CUR && !out_valid |=> !out_valid)
    else $error("write request produced a result");

  // read gives a result with zero y
  a_read_lat: assert property (@(posedge clk) disable iff (rst)
    accept && req_type == REQ_READ && !out_valid |=> ##1 out_valid && res_y == 0)
    else $error("read result missing or malformed");

  // busy once a vector transform is taken
  a_vec_busy: assert property (@(posedge clk) disable iff (rst)
    accept && req_type == REQ_VECTOR |=> in_stall)
    else $error("request taken during transform");

endmodule

bind affine_matrix_transform_engine amte_chk u_amte_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .req_type  (req_type),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .res_x     (res_x),
  .res_y     (res_y)
);
